// ===== src/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies; each macro expects clk and arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/pps_pkg.sv =====
// types and constants of the preemptive priority scheduler
// no dependencies; used by the core and its checker
package pps_pkg;

	localparam int IN_W  = 48;
	localparam int OUT_W = 144;

	localparam int OUT_TIME_LSB = 0;
	localparam int OUT_BUSY_BIT = 32;
	localparam int OUT_SLOT_LSB = 33;
	localparam int OUT_ID_LSB   = 37;
	localparam int OUT_FIN_BIT  = 45;
	localparam int OUT_CT_LSB   = 46;
	localparam int OUT_TAT_LSB  = 78;
	localparam int OUT_WT_LSB   = 110;
	localparam int OUT_ALL_BIT  = 142;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	localparam logic [31:0] CLOCK_MAX = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [15:0] remaining;
		logic [7:0]  prio;
		logic [15:0] burst;
		logic [15:0] arrival;
		logic [7:0]  task_id;
	} task_t;

	localparam int TASK_W = $bits(task_t);

	typedef struct packed {
		logic [7:0]  prio;
		logic [15:0] burst;
		logic [15:0] arrival;
		logic [7:0]  task_id;
	} load_t;

	typedef struct packed {
		logic        pad;
		logic        all_done;
		logic [31:0] waiting;
		logic [31:0] turnaround;
		logic [31:0] completion_time;
		logic        finished;
		logic [7:0]  run_id;
		logic [3:0]  run_slot;
		logic        busy_res;
		logic [31:0] tick_time;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FETCH,
		ST_UPD,
		ST_FIN
	} state_t;

endpackage

// ===== src/pps_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module pps_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/preemptive_priority_scheduler_core.sv =====
// preemptive priority scheduler: task table in ram, scanned by one compare unit
// depends on pps_pkg and pps_ram
//
// input channel s_*: tuser[0] is the kind, 0 loads a task, 1 runs one tick.
// a load writes the next free table slot; loads into a full table are
// dropped. a load gives no result item. a tick scans the loaded slots one
// per cycle through the single ram read port and one priority compare, then
// reads the chosen slot back, updates its remaining time and forms the
// result in the output register; the next item can be taken once m_tvalid
// rises. an idle tick skips the read back and update.
// s_tready stays low during the tick.
// output channel m_*: one item per tick, held in an output register; loads are
// still taken while that item waits, and a following tick waits in its last
// step until the register is free when the receiver stalls.
// reset clears the task count, done count, clock and output valid; table
// contents need no reset since only loaded slots are ever read.
module preemptive_priority_scheduler_core #(
	parameter int MAX_TASKS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// task_id[7:0], arrival[23:8], burst[39:24], prio[47:40]
	input  logic [pps_pkg::IN_W-1:0]    s_tdata,
	// kind[0]
	input  logic [0:0]                  s_tuser,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// tick_time[31:0], busy_res[32], run_slot[36:33], run_id[44:37],
	// finished[45], completion_time[77:46], turnaround[109:78],
	// waiting[141:110], all_done[142], zero[143]
	output logic [pps_pkg::OUT_W-1:0]   m_tdata
);
	import pps_pkg::*;

	localparam int SW = $clog2(MAX_TASKS);
	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam logic [CW-1:0] FULL = CW'(MAX_TASKS);

	state_t state_q, state_d;

	logic [CW-1:0]  count_q;
	logic [CW-1:0]  done_q;
	logic [31:0]    clock_q;
	logic [CW-1:0]  idx_q;
	logic           cmp_vld_q;
	logic [SW-1:0]  cmp_slot_q;
	logic           found_q;
	logic [7:0]     best_q;
	logic [SW-1:0]  slot_q;
	logic [31:0]    ct_q;
	logic [31:0]    tat_q;
	logic [15:0]    burst_q;
	logic [7:0]     id_q;
	logic           fin_q;
	logic           out_vld_q;
	result_t        out_q;

	logic           we;
	logic [SW-1:0]  waddr;
	task_t          wdata;
	logic [SW-1:0]  raddr;
	logic [TASK_W-1:0] rdata_raw;
	task_t          rdata;
	load_t          ld;

	logic           accept;
	logic           is_load;
	logic           is_tick;
	logic           issue;
	logic           better;
	logic           out_free;
	logic [15:0]    rem_dec;
	logic [CW-1:0]  done_next;
	result_t        res_d;

	assign ld       = load_t'(s_tdata);
	assign rdata    = task_t'(rdata_raw);
	assign accept   = s_tvalid && s_tready;
	assign is_load  = accept && (s_tuser[0] == KIND_LOAD);
	assign is_tick  = accept && (s_tuser[0] == KIND_TICK);
	assign issue    = (state_q == ST_SCAN) && (idx_q < count_q);
	assign out_free = !out_vld_q || m_tready;
	assign rem_dec  = rdata.remaining - 16'd1;

	assign better = cmp_vld_q && ({16'b0, rdata.arrival} <= clock_q)
		&& (rdata.remaining != 16'd0) && (!found_q || (rdata.prio < best_q));

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

	pps_ram #(
		.WIDTH (TASK_W),
		.DEPTH (MAX_TASKS)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata_raw)
	);

	always_comb begin
		we    = 1'b0;
		waddr = count_q[SW-1:0];
		wdata = {ld.burst, ld.prio, ld.burst, ld.arrival, ld.task_id};
		if (is_load && (count_q < FULL)) begin
			we = 1'b1;
		end else if (state_q == ST_UPD) begin
			we              = 1'b1;
			waddr           = slot_q;
			wdata           = rdata;
			wdata.remaining = rem_dec;
		end
	end

	always_comb begin
		raddr = (state_q == ST_FETCH) ? slot_q : idx_q[SW-1:0];
	end

	always_comb begin
		done_next = done_q + CW'(fin_q);
		res_d                 = '0;
		res_d.tick_time       = clock_q;
		res_d.busy_res        = found_q;
		res_d.run_slot        = found_q ? 4'(slot_q) : 4'd0;
		res_d.run_id          = found_q ? id_q : 8'd0;
		res_d.finished        = fin_q;
		res_d.completion_time = fin_q ? ct_q : 32'd0;
		res_d.turnaround      = fin_q ? tat_q : 32'd0;
		res_d.waiting         = (fin_q && (tat_q >= {16'b0, burst_q}))
			? (tat_q - {16'b0, burst_q}) : 32'd0;
		res_d.all_done        = (done_next == count_q);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (is_tick) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (!issue && !cmp_vld_q) begin
					state_d = found_q ? ST_FETCH : ST_FIN;
				end
			end
			ST_FETCH: state_d = ST_UPD;
			ST_UPD:   state_d = ST_FIN;
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			done_q    <= '0;
			clock_q   <= '0;
			idx_q     <= '0;
			cmp_vld_q <= 1'b0;
			found_q   <= 1'b0;
			fin_q     <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (is_load && (count_q < FULL)) begin
				count_q <= count_q + CW'(1);
				if (ld.burst == 16'd0) begin
					done_q <= done_q + CW'(1);
				end
			end
			if (is_tick) begin
				idx_q     <= '0;
				cmp_vld_q <= 1'b0;
				found_q   <= 1'b0;
				fin_q     <= 1'b0;
			end
			if (state_q == ST_SCAN) begin
				cmp_vld_q <= issue;
				if (issue) begin
					idx_q <= idx_q + CW'(1);
				end
				if (better) begin
					found_q <= 1'b1;
				end
			end
			if (state_q == ST_UPD) begin
				fin_q <= (rem_dec == 16'd0);
			end
			if ((state_q == ST_FIN) && out_free) begin
				out_vld_q <= 1'b1;
				done_q    <= done_next;
				if (clock_q != CLOCK_MAX) begin
					clock_q <= clock_q + 32'd1;
				end
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			cmp_slot_q <= idx_q[SW-1:0];
		end
		if (better) begin
			best_q <= rdata.prio;
			slot_q <= cmp_slot_q;
		end
		if (state_q == ST_FETCH) begin
			ct_q <= (clock_q == CLOCK_MAX) ? clock_q : clock_q + 32'd1;
		end
		if (state_q == ST_UPD) begin
			tat_q   <= ct_q - {16'b0, rdata.arrival};
			burst_q <= rdata.burst;
			id_q    <= rdata.task_id;
		end
		if ((state_q == ST_FIN) && out_free) begin
			out_q <= res_d;
		end
	end

endmodule

// ===== src/pps_checker.sv =====
// port-level checker for the preemptive priority scheduler core, with its bind
// depends on pps_pkg and assert_macros.svh
`include "assert_macros.svh"

module pps_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic [0:0]                s_tuser,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [pps_pkg::OUT_W-1:0] m_tdata
);
	import pps_pkg::*;

	logic tick_acc;
	logic res_busy;
	logic res_fin;
	logic [12:0] res_run;
	logic [31:0] res_tat;
	logic [31:0] res_wt;

	assign tick_acc = s_tvalid && s_tready && (s_tuser[0] == KIND_TICK);
	assign res_busy = m_tdata[OUT_BUSY_BIT];
	assign res_fin  = m_tdata[OUT_FIN_BIT];
	assign res_run  = m_tdata[OUT_FIN_BIT:OUT_SLOT_LSB];
	assign res_tat  = m_tdata[OUT_TAT_LSB +: 32];
	assign res_wt   = m_tdata[OUT_WT_LSB +: 32];

	`ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed under stall")
	`ASSERT_NEXT(a_tick_busy, tick_acc, !s_tready, "input ready right after a tick item")
	`ASSERT_SAME(a_idle_zero, m_tvalid && !res_busy, res_run == 13'd0, "idle tick reports a task")
	`ASSERT_SAME(a_fin_wait, m_tvalid && res_fin, res_busy && (res_tat >= res_wt), "bad completion")

endmodule

bind preemptive_priority_scheduler_core pps_checker u_pps_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
